>>> src/pqs_pkg.sv
// Shared types and constants for the piecewise quintic sampler.
// Used by every module of the block; depends on nothing.
package pqs_pkg;

  localparam int MAX_KNOTS   = 16;
  localparam int MAX_DIMS    = 3;
  localparam int NCOEF       = 6;
  localparam int COEF_DEPTH  = (MAX_KNOTS - 1) * MAX_DIMS * NCOEF;
  localparam int COEF_AW     = $clog2(COEF_DEPTH);
  localparam int KNOT_IW     = $clog2(MAX_KNOTS);
  localparam int NK_W        = 5;
  localparam int ND_W        = 2;
  localparam int SEG_W       = 4;
  localparam int TIME_W      = 24;
  localparam int COEF_W      = 64;
  localparam int RES_W       = 48;
  localparam int ACC_W       = 192;
  localparam int LIMB_W      = 32;
  localparam int NLIMB       = ACC_W / LIMB_W;
  localparam int SCL_W       = COEF_W + 6;
  localparam int QDEPTH      = 2;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [1:0] OP_KNOT   = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic CFG_NUM_KNOTS = 1'b0;
  localparam logic CFG_NUM_DIMS  = 1'b1;

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // One queued job: a coefficient write or a classified sample
  typedef struct packed {
    logic                  is_sample;
    logic                  in_range;
    logic [SEG_W-1:0]      seg;
    logic [COEF_AW-1:0]    addr;
    logic [COEF_W-1:0]     coeff;
    logic [TIME_W-1:0]     tval;
  } pqs_item_t;

endpackage

>>> src/pqs_front.sv
// Front end: accepts items, keeps the knot table, does range test and
// segment search, and pushes coefficient writes and samples. Uses pqs_pkg.
module pqs_front import pqs_pkg::*; (
  input  logic                     clk,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic [3:0]               in_knot_or_segment,
  input  logic [1:0]               in_dim_select,
  input  logic [2:0]               in_power_select,
  input  logic signed [COEF_W-1:0] in_coeff_value,
  input  logic [TIME_W-1:0]        in_time_value,
  input  logic [NK_W-1:0]          num_knots,
  input  logic                     q_full,
  output logic                     push,
  output pqs_item_t                push_item
);

  logic [TIME_W-1:0] knots_r [MAX_KNOTS];
  logic              accept;
  logic [NK_W-1:0]   nk;
  logic [TIME_W-1:0] last_knot;
  logic              in_rng;
  logic [SEG_W-1:0]  seg;
  logic              coef_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (num_knots < NK_W'(2)) nk = NK_W'(2);
    else if (num_knots > NK_W'(MAX_KNOTS)) nk = NK_W'(MAX_KNOTS);
    else nk = num_knots;
  end

  assign last_knot = knots_r[KNOT_IW'(nk - NK_W'(1))];
  assign in_rng = (in_time_value >= knots_r[0]) && (in_time_value <= last_knot);

  // First segment whose end knot is at or after the time; last one otherwise
  always_comb begin
    seg = SEG_W'(nk - NK_W'(2));
    for (int s = MAX_KNOTS - 2; s >= 0; s--) begin
      if ((s + 1 < int'(nk)) && (knots_r[s + 1] >= in_time_value)) seg = SEG_W'(s);
    end
  end

  assign coef_ok = (int'(in_knot_or_segment) < MAX_KNOTS - 1) &&
                   (int'(in_dim_select) < MAX_DIMS) && (int'(in_power_select) < NCOEF);

  always_ff @(posedge clk) begin
    if (accept && in_opcode == OP_KNOT && int'(in_knot_or_segment) < MAX_KNOTS) begin
      knots_r[KNOT_IW'(in_knot_or_segment)] <= in_time_value;
    end
  end

  always_comb begin
    push = accept && ((in_opcode == OP_COEF && coef_ok) || in_opcode == OP_SAMPLE);
    push_item.is_sample = (in_opcode == OP_SAMPLE);
    push_item.in_range  = in_rng;
    push_item.seg       = in_rng ? seg : '0;
    push_item.addr      = COEF_AW'((int'(in_knot_or_segment) * MAX_DIMS +
                                    int'(in_dim_select)) * NCOEF + int'(in_power_select));
    push_item.coeff     = in_coeff_value;
    push_item.tval      = in_time_value;
  end

endmodule

>>> src/pqs_queue.sv
// Short job queue between front and back end.
// Uses pqs_pkg for the entry type and depth.
module pqs_queue import pqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pqs_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pqs_item_t head_item
);

  pqs_item_t      mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (int'(wp_r) == QDEPTH - 1) ? '0 : wp_r + QAW'(1);
    if (pop)  rp_nxt = (int'(rp_r) == QDEPTH - 1) ? '0 : rp_r + QAW'(1);
    if (push && !pop) cnt_nxt = cnt_r + (QAW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + (QAW+1)'(1))
    else $error("queue count did not advance");

endmodule

>>> src/pqs_back.sv
// Back end: coefficient memory and a sequential Horner engine that multiplies
// a 192-bit accumulator by the time one 32-bit limb per cycle. Uses pqs_pkg.
module pqs_back import pqs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ND_W-1:0]         num_dims,
  input  logic                    head_valid,
  input  pqs_item_t               head_item,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_in_range,
  output logic [SEG_W-1:0]        out_segment_found,
  output logic signed [RES_W-1:0] out_pos_x,
  output logic signed [RES_W-1:0] out_pos_y,
  output logic signed [RES_W-1:0] out_pos_z,
  output logic signed [RES_W-1:0] out_vel_x,
  output logic signed [RES_W-1:0] out_vel_y,
  output logic signed [RES_W-1:0] out_vel_z,
  output logic signed [RES_W-1:0] out_acc_x,
  output logic signed [RES_W-1:0] out_acc_y,
  output logic signed [RES_W-1:0] out_acc_z
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_OUT   = 6'b100000
  } st_t;

  logic [COEF_W-1:0]       coef_mem [COEF_DEPTH];
  st_t                     state_r;
  logic [COEF_W-1:0]       rd_r;
  logic [TIME_W-1:0]       time_r;
  logic [SEG_W-1:0]        seg_r;
  logic                    rng_r;
  logic [ND_W-1:0]         nd_r;
  logic [ND_W-1:0]         dim_r;
  logic [1:0]              ord_r;
  logic [2:0]              j_r;
  logic [2:0]              limb_r;
  logic signed [SCL_W-1:0] e_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        p_r;
  logic [RES_W-1:0]        pos_r [MAX_DIMS];
  logic [RES_W-1:0]        vel_r [MAX_DIMS];
  logic [RES_W-1:0]        acl_r [MAX_DIMS];

  logic [ND_W-1:0]         nd;
  logic [2:0]              cidx;
  logic [4:0]              kmul;
  logic [COEF_AW-1:0]      rd_addr;
  logic [LIMB_W+TIME_W-1:0] pp;
  logic [ACC_W-1:0]        pp_sh;
  logic [ACC_W-1:0]        e_sh;
  logic [ACC_W-1:0]        p_sum;
  logic [2:0]              jtop;
  logic [ACC_W-1:0]        rnd;
  logic [RES_W-1:0]        res;

  always_comb begin
    if (num_dims < ND_W'(1)) nd = ND_W'(1);
    else if (num_dims > ND_W'(MAX_DIMS)) nd = ND_W'(MAX_DIMS);
    else nd = num_dims;
  end

  assign jtop = 3'(5) - 3'(ord_r);
  assign cidx = j_r + 3'(ord_r);
  assign rd_addr = COEF_AW'((int'(seg_r) * MAX_DIMS + int'(dim_r)) * NCOEF + int'(cidx));

  // Derivative weight of coefficient i: 1, i or i(i-1)
  always_comb begin
    unique case (ord_r)
      2'd0:    kmul = 5'd1;
      2'd1:    kmul = 5'(cidx);
      default: kmul = 5'(cidx) * (5'(cidx) - 5'd1);
    endcase
  end

  assign pp    = acc_r[limb_r * LIMB_W +: LIMB_W] * time_r;
  assign pp_sh = ACC_W'(pp) << (limb_r * LIMB_W);
  assign e_sh  = {{(ACC_W-SCL_W){e_r[SCL_W-1]}}, e_r} << (8'd16 * 8'(jtop - j_r));
  assign p_sum = ((limb_r == '0) ? e_sh : p_r) + pp_sh;

  // Round to 2^-24 (ties up) and saturate
  always_comb begin
    rnd = acc_r + (ACC_W'(1) << (8'd95 - 8'd16 * 8'(ord_r)));
    unique case (ord_r)
      2'd0: res = (&rnd[ACC_W-1:143] || ~|rnd[ACC_W-1:143]) ? rnd[143:96] :
                  (rnd[ACC_W-1] ? RES_MIN : RES_MAX);
      2'd1: res = (&rnd[ACC_W-1:127] || ~|rnd[ACC_W-1:127]) ? rnd[127:80] :
                  (rnd[ACC_W-1] ? RES_MIN : RES_MAX);
      default: res = (&rnd[ACC_W-1:111] || ~|rnd[ACC_W-1:111]) ? rnd[111:64] :
                     (rnd[ACC_W-1] ? RES_MIN : RES_MAX);
    endcase
  end

  assign pop = (state_r == ST_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (pop && !head_item.is_sample) coef_mem[head_item.addr] <= head_item.coeff;
    if (state_r == ST_FETCH) rd_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop && head_item.is_sample) begin
            time_r <= head_item.tval;
            seg_r  <= head_item.seg;
            rng_r  <= head_item.in_range;
            nd_r   <= nd;
            dim_r  <= '0;
            ord_r  <= '0;
            j_r    <= 3'd5;
            acc_r  <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
              pos_r[d] <= '0;
              vel_r[d] <= '0;
              acl_r[d] <= '0;
            end
            state_r <= head_item.in_range ? ST_FETCH : ST_OUT;
          end
        end
        ST_FETCH: state_r <= ST_SCALE;
        ST_SCALE: begin
          e_r     <= SCL_W'($signed(rd_r) * $signed({1'b0, kmul}));
          limb_r  <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (int'(limb_r) == NLIMB - 1) begin
            acc_r <= p_sum;
            if (j_r == '0) begin
              state_r <= ST_FIN;
            end else begin
              j_r     <= j_r - 3'd1;
              state_r <= ST_FETCH;
            end
          end else begin
            p_r    <= p_sum;
            limb_r <= limb_r + 3'd1;
          end
        end
        ST_FIN: begin
          unique case (ord_r)
            2'd0:    pos_r[dim_r] <= res;
            2'd1:    vel_r[dim_r] <= res;
            default: acl_r[dim_r] <= res;
          endcase
          acc_r <= '0;
          if (ord_r != 2'd2) begin
            ord_r   <= ord_r + 2'd1;
            j_r     <= 3'd4 - 3'(ord_r);
            state_r <= ST_FETCH;
          end else if (dim_r + ND_W'(1) < nd_r) begin
            dim_r   <= dim_r + ND_W'(1);
            ord_r   <= '0;
            j_r     <= 3'd5;
            state_r <= ST_FETCH;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = (state_r == ST_OUT);
  assign out_in_range      = rng_r;
  assign out_segment_found = seg_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_vel_x = vel_r[0];
  assign out_vel_y = vel_r[1];
  assign out_vel_z = vel_r[2];
  assign out_acc_x = acl_r[0];
  assign out_acc_y = acl_r[1];
  assign out_acc_z = acl_r[2];

  a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> int'(limb_r) < NLIMB)
    else $error("limb counter out of range");
  a_coef_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH |-> (j_r <= jtop) && (dim_r < nd_r))
    else $error("coefficient index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

>>> src/piecewise_quintic_sampler_core.sv
// Piecewise quintic sampler: knot table and coefficient memory loaded by
// items, samples evaluated to position, velocity and acceleration.
// Input channel in_*: valid/stall. Opcode 0 writes a knot time, 1 writes a
//   coefficient, 2 samples at in_time_value; other codes are dropped.
// Result channel out_*: valid/stall, one result per sample item only.
// Config channel cfg_*: valid/ready, index 0 num_knots, 1 num_dims; always
//   ready, write only while no sample is in flight.
// Knot writes and range/segment search happen at input accept; coefficient
//   writes and samples pass a two-entry queue to the evaluation engine.
// Throughput: the engine stores a coefficient write while idle and can take
//   the next item straight away. A sample holds the engine until its result
//   leaves: each Horner step is a memory fetch, a scale step and 32x24 limb
//   multiplies into the 192-bit accumulator, and those multiplies dominate.
// The result register holds while out_stall is high; the front keeps taking
//   items until the queue fills, then raises in_stall.
// Reset clears control state and sets num_knots 2, num_dims 3; the tables
//   are undefined until written.
module piecewise_quintic_sampler_core import pqs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_opcode,
  input  logic [3:0]              in_knot_or_segment,
  input  logic [1:0]              in_dim_select,
  input  logic [2:0]              in_power_select,
  input  logic signed [63:0]      in_coeff_value,
  input  logic [23:0]             in_time_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_in_range,
  output logic [3:0]              out_segment_found,
  output logic signed [47:0]      out_pos_x,
  output logic signed [47:0]      out_pos_y,
  output logic signed [47:0]      out_pos_z,
  output logic signed [47:0]      out_vel_x,
  output logic signed [47:0]      out_vel_y,
  output logic signed [47:0]      out_vel_z,
  output logic signed [47:0]      out_acc_x,
  output logic signed [47:0]      out_acc_y,
  output logic signed [47:0]      out_acc_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [4:0]              cfg_data
);

  logic [NK_W-1:0] num_knots_r;
  logic [ND_W-1:0] num_dims_r;
  logic            q_full, push, pop, head_valid;
  pqs_item_t       push_item, head_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_knots_r <= NK_W'(2);
      num_dims_r  <= ND_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_KNOTS: num_knots_r <= cfg_data;
        CFG_NUM_DIMS:  num_dims_r  <= cfg_data[ND_W-1:0];
      endcase
    end
  end

  pqs_front u_front (
    .clk, .in_valid, .in_stall, .in_opcode, .in_knot_or_segment,
    .in_dim_select, .in_power_select, .in_coeff_value, .in_time_value,
    .num_knots(num_knots_r), .q_full, .push, .push_item
  );

  pqs_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full(q_full), .pop, .head_valid, .head_item
  );

  pqs_back u_back (
    .clk, .rst_n, .num_dims(num_dims_r), .head_valid, .head_item, .pop,
    .out_valid, .out_stall, .out_in_range, .out_segment_found,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_vel_x, .out_vel_y, .out_vel_z,
    .out_acc_x, .out_acc_y, .out_acc_z
  );

endmodule

>>> test/piecewise_quintic_sampler_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_quintic_sampler_core: loads knots and
// coefficients, samples at random times and checks every result against a
// built-in exact-arithmetic predictor. Depends on src/pqs_pkg.sv and the core.
module piecewise_quintic_sampler_core_tb;
  import pqs_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE       = 60;
  localparam int HOLD_CYCLES  = 4000;

  typedef struct packed {
    logic                  in_range;
    logic [3:0]            seg;
    logic [8:0][RES_W-1:0] val;
  } sample_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_knot_or_segment = '0;
  logic [1:0] in_dim_select = '0;
  logic [2:0] in_power_select = '0;
  logic signed [63:0] in_coeff_value = '0;
  logic [23:0] in_time_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_in_range;
  logic [3:0] out_segment_found;
  logic signed [47:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [47:0] out_vel_x, out_vel_y, out_vel_z;
  logic signed [47:0] out_acc_x, out_acc_y, out_acc_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_NUM_KNOTS;
  logic [4:0] cfg_data = '0;

  piecewise_quintic_sampler_core DUT (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic [TIME_W-1:0] knot_tab [MAX_KNOTS];
  logic [COEF_W-1:0] coef_tab [MAX_KNOTS-1][MAX_DIMS][NCOEF];
  logic [4:0] num_knots_reg = 5'd2;
  logic [1:0] num_dims_reg = 2'd3;
  sample_result_t pending_results [$];

  int err_count = 0;
  int cycle_count = 0;
  bit tx_steady = 0;
  bit rx_steady = 0;
  bit hold_req = 0;
  logic hold_on = 1'b0;
  int rx_wait = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Exact derivative of a segment quintic, rounded half up and saturated
  function automatic logic [RES_W-1:0] quintic_deriv(int seg, int dim, logic [23:0] t,
                                                     int order);
    logic signed [255:0] acc, tp, ce, lim;
    int k, j;
    acc = '0;
    for (int i = order; i < NCOEF; i++) begin
      j = i - order;
      k = (order == 0) ? 1 : (order == 1) ? i : i * (i - 1);
      tp = 256'sd1 <<< (16 * (5 - j));
      repeat (j) tp = tp * $signed({232'd0, t});
      ce = {{192{coef_tab[seg][dim][i][63]}}, coef_tab[seg][dim][i]};
      acc = acc + tp * ce * k;
    end
    acc = acc + (256'sd1 <<< 95);
    acc = acc >>> 96;
    lim = 256'sd1 <<< 47;
    if (acc >= lim) return RES_MAX;
    if (acc < -lim) return RES_MIN;
    return acc[RES_W-1:0];
  endfunction

  function automatic sample_result_t sample_at(logic [23:0] t);
    sample_result_t r;
    int nk, nd, seg;
    r = '0;
    nk = (num_knots_reg < 2) ? 2 : (num_knots_reg > MAX_KNOTS) ? MAX_KNOTS : num_knots_reg;
    nd = (num_dims_reg < 1) ? 1 : num_dims_reg;
    if (t < knot_tab[0] || t > knot_tab[nk-1]) return r;
    seg = nk - 2;
    for (int s = 0; s + 1 < nk; s++) begin
      if (knot_tab[s+1] >= t) begin
        seg = s;
        break;
      end
    end
    r.in_range = 1'b1;
    r.seg = seg[3:0];
    for (int d = 0; d < nd; d++) begin
      r.val[d]     = quintic_deriv(seg, d, t, 0);
      r.val[3 + d] = quintic_deriv(seg, d, t, 1);
      r.val[6 + d] = quintic_deriv(seg, d, t, 2);
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [1:0] dim, logic [2:0] pw,
                           logic [63:0] cv, logic [23:0] tv);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= op;
    in_knot_or_segment <= idx;
    in_dim_select <= dim;
    in_power_select <= pw;
    in_coeff_value <= cv;
    in_time_value <= tv;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // item accepted at this edge: advance the predictor
    case (op)
      OP_KNOT: knot_tab[idx] = tv;
      OP_COEF: if (idx < MAX_KNOTS - 1 && dim < MAX_DIMS && pw < NCOEF)
                 coef_tab[idx][dim][pw] = cv;
      OP_SAMPLE: pending_results.push_back(sample_at(tv));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_KNOTS) num_knots_reg = data;
    else num_dims_reg = data[1:0];
  endtask

  function automatic logic [63:0] rand_coef();
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    return r >>> $urandom_range(0, 63);
  endfunction

  task automatic load_knots_ascending();
    logic [24:0] t;
    t = ($urandom_range(0, 3) == 0) ? 25'd0 : 25'($urandom_range(0, 5000));
    for (int i = 0; i < MAX_KNOTS; i++) begin
      send_item(OP_KNOT, i[3:0], 2'd0, 3'd0, 64'd0, (t > 25'hFFFFFF) ? 24'hFFFFFF : t[23:0]);
      t = 25'(t + $urandom_range(1, 1 << $urandom_range(4, 19)));
    end
  endtask

  function automatic logic [23:0] pick_time();
    int nk, r;
    nk = (num_knots_reg < 2) ? 2 : (num_knots_reg > MAX_KNOTS) ? MAX_KNOTS : num_knots_reg;
    r = $urandom_range(0, 9);
    if (r < 2) return 24'($urandom_range(0, 24'hFFFFFF));
    if (r < 3) return knot_tab[$urandom_range(0, nk - 1)];
    if (knot_tab[nk-1] < knot_tab[0]) return 24'($urandom_range(0, 24'hFFFFFF));
    return 24'($urandom_range(knot_tab[0], knot_tab[nk-1]));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) send_item(OP_SAMPLE, 4'($urandom), 2'($urandom), 3'($urandom),
                          {$urandom, $urandom}, pick_time());
    else if (r < 92) send_item(OP_COEF, 4'($urandom_range(0, 14)), 2'($urandom_range(0, 2)),
                               3'($urandom_range(0, 5)), rand_coef(), 24'($urandom));
    else if (r < 96) send_item(OP_KNOT, 4'($urandom), 2'($urandom), 3'($urandom),
                               {$urandom, $urandom}, 24'($urandom));
    else send_item(($urandom_range(0, 1) != 0) ? OP_NONE : OP_COEF, 4'd15, 2'd3, 3'd7,
                   {$urandom, $urandom}, 24'($urandom));
  endtask

  // Fill every table entry so no sample ever reads an unwritten one
  task automatic test_table_load();
    load_knots_ascending();
    for (int s = 0; s < MAX_KNOTS - 1; s++)
      for (int d = 0; d < MAX_DIMS; d++)
        for (int p = 0; p < NCOEF; p++)
          send_item(OP_COEF, s[3:0], d[1:0], p[2:0], rand_coef(), 24'($urandom));
    repeat (10) send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, pick_time());
    wait_idle();
  endtask

  task automatic test_directed();
    write_cfg(CFG_NUM_KNOTS, 5'd2);
    write_cfg(CFG_NUM_DIMS, 5'd3);
    send_item(OP_KNOT, 4'd0, 2'd0, 3'd0, 64'd0, 24'd0);
    send_item(OP_KNOT, 4'd1, 2'd0, 3'd0, 64'd0, 24'hFFFFFF);
    // saturating coefficients in segment 0
    send_item(OP_COEF, 4'd0, 2'd0, 3'd5, 64'h7FFFFFFFFFFFFFFF, 24'd0);
    send_item(OP_COEF, 4'd0, 2'd1, 3'd5, 64'h8000000000000000, 24'd0);
    send_item(OP_COEF, 4'd0, 2'd2, 3'd0, 64'h0000008000000000, 24'd0);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'd0);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'hFFFFFF);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h010000);
    // writes that must be dropped, and the unused opcode
    send_item(OP_COEF, 4'd15, 2'd0, 3'd0, 64'h1234, 24'd0);
    send_item(OP_COEF, 4'd0, 2'd3, 3'd0, 64'h1234, 24'd0);
    send_item(OP_COEF, 4'd0, 2'd0, 3'd6, 64'h1234, 24'd0);
    send_item(OP_COEF, 4'd0, 2'd0, 3'd7, 64'h1234, 24'd0);
    send_item(OP_NONE, 4'hF, 2'd3, 3'd7, 64'hFFFFFFFFFFFFFFFF, 24'hFFFFFF);
    send_item(OP_SAMPLE, 4'hF, 2'd3, 3'd7, 64'hFFFFFFFFFFFFFFFF, 24'h800000);
    // out of range below and above, and exact knot boundaries
    send_item(OP_KNOT, 4'd0, 2'd0, 3'd0, 64'd0, 24'h000100);
    send_item(OP_KNOT, 4'd1, 2'd0, 3'd0, 64'd0, 24'h000200);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h0000FF);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h000201);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h000100);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h000200);
    // knots out of order: the literal search still takes segment 0 here
    send_item(OP_KNOT, 4'd2, 2'd0, 3'd0, 64'd0, 24'h000150);
    wait_idle();
    write_cfg(CFG_NUM_KNOTS, 5'd3);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h000120);
    send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, 24'h000140);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [4:0] knot_set [8] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd7, 5'd16};
    logic [1:0] dim_set [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd2, 2'd0};
    load_knots_ascending();
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      write_cfg(CFG_NUM_KNOTS, knot_set[i]);
      write_cfg(CFG_NUM_DIMS, 5'(dim_set[i]));
      repeat (12) send_item(OP_SAMPLE, 4'($urandom), 2'($urandom), 3'($urandom),
                            {$urandom, $urandom}, pick_time());
      wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 270; i++) begin
      if (i % 100 == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_steady = ($urandom_range(0, 2) == 0);
      end
      if (i % 150 == 75) begin
        wait_idle();
        write_cfg(CFG_NUM_KNOTS, 5'($urandom_range(2, 16)));
        write_cfg(CFG_NUM_DIMS, 5'($urandom_range(1, 3)));
        load_knots_ascending();
      end
      random_item();
    end
    tx_steady = 0;
    rx_steady = 0;
    wait_idle();
  endtask

  // Hold the result side off for a long stretch so the input stalls
  task automatic test_backpressure();
    tx_steady = 1;
    hold_req = 1;
    repeat (12) send_item(OP_SAMPLE, 4'd0, 2'd0, 3'd0, 64'd0, pick_time());
    tx_steady = 0;
    wait_idle();
  endtask

  always begin
    wait (hold_req);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
    hold_req = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_wait = rx_steady ? 0 : $urandom_range(0, 13);
      else if (rx_wait > 0) rx_wait--;
      out_stall <= hold_on || (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    sample_result_t got, want;
    string names [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                         "acc_x", "acc_y", "acc_z"};
    if (rst_n && out_valid && !out_stall) begin
      got.in_range = out_in_range;
      got.seg = out_segment_found;
      got.val = {out_acc_z, out_acc_y, out_acc_x, out_vel_z, out_vel_y, out_vel_x,
                 out_pos_z, out_pos_y, out_pos_x};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.seg), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.in_range !== want.in_range)
          report_mismatch("in_range", 64'(got.in_range), 64'(want.in_range));
        if (got.seg !== want.seg)
          report_mismatch("segment_found", 64'(got.seg), 64'(want.seg));
        for (int i = 0; i < 9; i++)
          if (got.val[i] !== want.val[i])
            report_mismatch(names[i], 64'(got.val[i]), 64'(want.val[i]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
